// ----- design/activity_power_mode_controller_defines.svh -----
// Assertion macros used by the checker file of the power mode controller.
`ifndef ACTIVITY_POWER_MODE_CONTROLLER_DEFINES_SVH
`define ACTIVITY_POWER_MODE_CONTROLLER_DEFINES_SVH

// Checked on every rising edge of clk, switched off while rst_n is low.
`define APMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define APMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/apmc_pkg.sv -----
package apmc_pkg;

  // Number of accelerometer axes tracked by default.
  localparam int AXES_DEF = 3;

  // Port widths.
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Timing and scaling constants.
  localparam logic [7:0] SAMPLE_ACTIVE_MS = 8'd50;
  localparam logic [7:0] SAMPLE_IDLE_MS   = 8'd200;
  localparam int         MS_PER_S         = 1000;
  localparam int         DEV_SHIFT        = 12;
  localparam int         GRAV_SHIFT       = 3;
  localparam logic [1:0] HIT_MIN          = 2'd2;
  localparam logic [1:0] HIT_MAX          = 2'd3;

  // Register reset values.
  localparam logic [13:0] THRESHOLD_RST      = 14'd200;
  localparam int          ACTIVE_TIMEOUT_RST = 30;
  localparam int          DROWSY_MIN_RST     = 60;
  localparam logic [15:0] WINDOW_RST         = 16'd1000;

  // Output encoding of the power mode.
  localparam logic [1:0] PM_ACTIVE = 2'd0;
  localparam logic [1:0] PM_DROWSY = 2'd1;
  localparam logic [1:0] PM_SLEEP  = 2'd2;

  // Commands carried with each input item.
  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_WAKE       = 2'd1,
    CMD_SLEEP_DONE = 2'd2,
    CMD_FRAME      = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 3'd0,
    CFG_ACT_TMO    = 3'd1,
    CFG_DROWSY_MIN = 3'd2,
    CFG_IMU        = 3'd3,
    CFG_MODE_EN    = 3'd4,
    CFG_WINDOW     = 3'd5
  } cfg_idx_t;

  // Power mode state, one-hot.
  typedef enum logic [2:0] {
    MODE_ACTIVE = 3'b001,
    MODE_DROWSY = 3'b010,
    MODE_SLEEP  = 3'b100
  } mode_t;

  // Converts the internal state to the output code.
  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] code;
    case (m)
      MODE_ACTIVE: code = PM_ACTIVE;
      MODE_DROWSY: code = PM_DROWSY;
      MODE_SLEEP:  code = PM_SLEEP;
      default:     code = PM_ACTIVE;
    endcase
    return code;
  endfunction

  // True when timestamp a lies strictly after b on the wrapping time line.
  function automatic logic newer(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

// ----- design/activity_power_mode_controller.sv -----
// Activity power mode controller: every input item (tick, wake, light sleep done or
// frame window) yields exactly one result item carrying the power mode, the full
// power hold, the recent motion flag and whether a mode was entered. An item is
// taken into an input register and its whole update is done in one pass of logic
// into the result register, so the block accepts one item per clock cycle while
// the output is not stalled. The result item is offered from the result register
// once it has moved on from the input register; a stalled result holds the
// item behind it in the input register, and the input is refused only while both
// registers are full.
// The clock rate is set by that single pass, whose longest path runs through the axis
// deviation, the mg scaling multiplier and the timeout compares. Configuration
// writes are registered directly; the timeouts are held pre-scaled to milliseconds.
module activity_power_mode_controller #(
  parameter int AXES = apmc_pkg::AXES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // From bit 0: now_ms[31:0], touch_time[31:0], accel_valid, accel_x[15:0],
  // accel_y[15:0], accel_z[15:0], woke_by_timeout, allow_sleep, zero fill.
  input  logic [apmc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // From bit 0: command[1:0].
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // From bit 0: power_mode[1:0], hold_full_power, motion_recent, mode_changed,
  // zero fill.
  output logic [apmc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [apmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apmc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import apmc_pkg::*;

  localparam int NOW_LSB   = 0;
  localparam int TOUCH_LSB = 32;
  localparam int AV_BIT    = 64;
  localparam int ACC_LSB   = 65;
  localparam int WOKE_BIT  = 113;
  localparam int ALLOW_BIT = 114;

  // Configuration registers.
  logic [13:0] threshold_r;
  logic [25:0] act_tmo_ms_r;
  logic [25:0] drowsy_ms_r;
  logic        imu_r;
  logic        mode_en_r;
  logic [15:0] window_r;

  // Input register.
  logic                  s1_valid_r;
  logic [IN_TDATA_W-1:0] s1_data_r;
  cmd_t                  s1_cmd_r;
  logic                  advance;

  // Result register.
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  // Controller state.
  mode_t       mode_r, mode_nxt;
  logic [31:0] mode_since_r, mode_since_nxt;
  logic [31:0] last_act_r, last_act_nxt;
  logic [31:0] last_motion_r, last_motion_nxt;
  logic [31:0] last_sample_r, last_sample_nxt;
  logic        grav_ready_r, grav_ready_nxt;
  logic [1:0]  hit_count_r, hit_count_nxt;
  logic        hold_r, hold_nxt;
  logic signed [15:0] grav_r   [AXES];
  logic signed [15:0] grav_nxt [AXES];

  // Unpacked fields of the held item.
  logic [31:0]        now_ms;
  logic [31:0]        touch_time;
  logic               accel_valid;
  logic               woke_by_timeout;
  logic               allow_sleep;
  logic signed [15:0] accel [AXES];

  // Deviation path.
  logic signed [16:0] dev      [AXES];
  logic signed [16:0] dev_step [AXES];
  logic [15:0]        dev_abs  [AXES];
  logic signed [15:0] grav_upd [AXES];
  logic [15:0]        dev_max;
  logic [25:0]        dev_prod;
  logic               is_motion;

  logic       changed;
  logic       motion_recent;
  logic [7:0] period;
  logic [1:0] hit_inc;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  assign now_ms          = s1_data_r[NOW_LSB +: 32];
  assign touch_time      = s1_data_r[TOUCH_LSB +: 32];
  assign accel_valid     = s1_data_r[AV_BIT];
  assign woke_by_timeout = s1_data_r[WOKE_BIT];
  assign allow_sleep     = s1_data_r[ALLOW_BIT];

  // Configuration writes; the two timeouts are stored in milliseconds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RST;
      act_tmo_ms_r <= 26'(ACTIVE_TIMEOUT_RST * MS_PER_S);
      drowsy_ms_r  <= 26'(DROWSY_MIN_RST * MS_PER_S);
      imu_r        <= 1'b1;
      mode_en_r    <= 1'b1;
      window_r     <= WINDOW_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:  threshold_r  <= cfg_wdata[13:0];
        CFG_ACT_TMO:    act_tmo_ms_r <= 26'(cfg_wdata) * 26'(MS_PER_S);
        CFG_DROWSY_MIN: drowsy_ms_r  <= 26'(cfg_wdata) * 26'(MS_PER_S);
        CFG_IMU:        imu_r        <= cfg_wdata[0];
        CFG_MODE_EN:    mode_en_r    <= cfg_wdata[0];
        CFG_WINDOW:     window_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: takes an item whenever it is empty or the held one moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_cmd_r  <= cmd_t'(in_tuser);
    end
  end

  // Per-axis deviation from the gravity estimate, its magnitude and the low-pass step.
  always_comb begin
    dev_max = 16'd0;
    for (int i = 0; i < AXES; i++) begin
      accel[i]    = s1_data_r[ACC_LSB + 16*i +: 16];
      dev[i]      = {accel[i][15], accel[i]} - {grav_r[i][15], grav_r[i]};
      dev_abs[i]  = dev[i][16] ? 16'(-dev[i]) : dev[i][15:0];
      // The arithmetic shift rounds the step towards minus infinity.
      dev_step[i] = dev[i] >>> GRAV_SHIFT;
      grav_upd[i] = grav_r[i] + dev_step[i][15:0];
      if (dev_abs[i] > dev_max) begin
        dev_max = dev_abs[i];
      end
    end
  end

  // Scale the largest deviation to mg and compare with the threshold.
  assign dev_prod  = 26'(dev_max) * 26'(MS_PER_S);
  assign is_motion = dev_prod[25:DEV_SHIFT] >= threshold_r;
  assign hit_inc   = (hit_count_r == HIT_MAX) ? HIT_MAX : hit_count_r + 2'd1;

  // Next state for the held item.
  always_comb begin
    mode_nxt        = mode_r;
    mode_since_nxt  = mode_since_r;
    last_act_nxt    = last_act_r;
    last_motion_nxt = last_motion_r;
    last_sample_nxt = last_sample_r;
    grav_ready_nxt  = grav_ready_r;
    hit_count_nxt   = hit_count_r;
    hold_nxt        = hold_r;
    changed         = 1'b0;
    period          = (mode_r == MODE_ACTIVE) ? SAMPLE_ACTIVE_MS : SAMPLE_IDLE_MS;
    for (int i = 0; i < AXES; i++) begin
      grav_nxt[i] = grav_r[i];
    end

    case (s1_cmd_r)
      CMD_TICK: begin
        // Touch counts only when it is newer than the last activity.
        if (touch_time != 32'd0 && newer(touch_time, last_act_r)) begin
          last_act_nxt = touch_time;
        end
        // Sample slot; an invalid reading uses it up and changes nothing else.
        if (imu_r && (now_ms - last_sample_r) >= {24'd0, period}) begin
          last_sample_nxt = now_ms;
          if (accel_valid) begin
            if (!grav_ready_r) begin
              for (int i = 0; i < AXES; i++) begin
                grav_nxt[i] = accel[i];
              end
              grav_ready_nxt = 1'b1;
            end else begin
              for (int i = 0; i < AXES; i++) begin
                grav_nxt[i] = grav_upd[i];
              end
              if (is_motion) begin
                hit_count_nxt = hit_inc;
                if (hit_inc >= HIT_MIN) begin
                  last_motion_nxt = now_ms;
                  last_act_nxt    = now_ms;
                end
              end else begin
                hit_count_nxt = 2'd0;
              end
            end
          end
        end
        // Timeout driven mode changes.
        if (mode_en_r) begin
          case (mode_r)
            MODE_ACTIVE: begin
              if ((now_ms - last_act_nxt) >= {6'd0, act_tmo_ms_r}) begin
                mode_nxt = MODE_DROWSY;
                changed  = 1'b1;
              end
            end
            MODE_DROWSY: begin
              if (newer(last_act_nxt, mode_since_r)) begin
                mode_nxt = MODE_ACTIVE;
                changed  = 1'b1;
              end else if ((now_ms - mode_since_r) >= {6'd0, drowsy_ms_r}) begin
                mode_nxt = MODE_SLEEP;
                changed  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_WAKE: begin
        last_act_nxt    = now_ms;
        last_motion_nxt = now_ms;
        mode_nxt        = MODE_ACTIVE;
        changed         = 1'b1;
      end
      CMD_SLEEP_DONE: begin
        hold_nxt = 1'b0;
        if (imu_r && !woke_by_timeout) begin
          grav_ready_nxt = 1'b0;
          hit_count_nxt  = 2'd0;
        end
      end
      CMD_FRAME: begin
        if (mode_r == MODE_DROWSY) begin
          hold_nxt = !allow_sleep;
        end
      end
      default: ;
    endcase

    // Entering a mode restarts its timer and sets the hold, or clears it for SLEEP.
    if (changed) begin
      mode_since_nxt = now_ms;
      hold_nxt       = (mode_nxt != MODE_SLEEP);
    end
  end

  assign motion_recent = (last_motion_nxt != 32'd0) &&
                         ((now_ms - last_motion_nxt) <= {16'd0, window_r});

  assign out_data_nxt  = {3'd0, changed, motion_recent, hold_nxt, mode_code(mode_nxt)};
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  // State update when the item moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_ACTIVE;
      mode_since_r  <= 32'd0;
      last_act_r    <= 32'd0;
      last_motion_r <= 32'd0;
      last_sample_r <= 32'd0;
      grav_ready_r  <= 1'b0;
      hit_count_r   <= 2'd0;
      hold_r        <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        mode_r        <= mode_nxt;
        mode_since_r  <= mode_since_nxt;
        last_act_r    <= last_act_nxt;
        last_motion_r <= last_motion_nxt;
        last_sample_r <= last_sample_nxt;
        grav_ready_r  <= grav_ready_nxt;
        hit_count_r   <= hit_count_nxt;
        hold_r        <= hold_nxt;
      end
    end
  end

  // Gravity estimate and result payload carry no reset.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
      for (int i = 0; i < AXES; i++) begin
        grav_r[i] <= grav_nxt[i];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- design/apmc_checker.sv -----
`include "activity_power_mode_controller_defines.svh"

module apmc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  import apmc_pkg::*;

  logic       res_changed;
  logic       res_hold;
  logic [1:0] res_mode;

  assign res_mode    = out_tdata[1:0];
  assign res_hold    = out_tdata[2];
  assign res_changed = out_tdata[4];

  // A result waiting for the sink keeps its value.
  `APMC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result item changed")

  // Entering SLEEP always drops the full power hold.
  `APMC_ASSERT(a_sleep_entry, out_tvalid && res_changed && res_mode == PM_SLEEP |-> !res_hold, "SLEEP entered with hold set")

  // Entering ACTIVE or DROWSY always sets the full power hold.
  `APMC_ASSERT(a_wake_entry, out_tvalid && res_changed && (res_mode == PM_ACTIVE || res_mode == PM_DROWSY) |-> res_hold, "mode entered without hold")

  // With the result register empty there is always room for an input item.
  `APMC_ASSERT(a_in_ready, !out_tvalid |-> in_tready, "input item refused with the result register empty")

  // No result item is offered straight after a reset cycle.
  `APMC_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> !out_tvalid, "result item offered after reset")

endmodule

bind activity_power_mode_controller apmc_checker u_apmc_checker (.*);
